/* hdl/sut_pkg.sv */
package sut_pkg;

    // Table geometry
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = 7;
    localparam int VALUE_W = 32;

    // Requested operation of one input beat
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2
    } t_action;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // Source of the result value
    typedef enum logic [1:0] {
        VSEL_ZERO    = 2'd0,
        VSEL_OPERAND = 2'd1,
        VSEL_RDATA   = 2'd2
    } t_vsel;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;      // capture input beat, open search window
        logic    probe;     // read entry at search midpoint
        logic    eval;      // narrow search window from read data
        logic    shift_rd;  // read next entry to move up one place
        logic    place;     // write operand at insert position, count up
        logic    pop_rd;    // read top entry
        logic    pop;       // count down
        logic    emit;      // load result register
        t_status status;
        t_vsel   vsel;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_action action;
        logic    full;
        logic    empty;
        logic    search_open;
        logic    found;
        logic    shift_more;
        logic    out_free;
    } t_dp_stat;

endpackage

/* hdl/sorted_unique_set_table.sv */
// Sorted set table: holds up to 64 distinct signed 32-bit values in ascending
// order in a RAM with one read port, one write port and registered read. One
// beat is handled at a time; a new beat is taken while the previous result
// still waits on the output. A lookup binary-searches the table with up to 7
// probes; each probe reads the RAM at the search midpoint and then compares
// the read data. An insert runs the same search and, if the value is new,
// moves every entry above the insert position up one place, one entry per
// cycle through the RAM ports, then places the operand. A remove reads the
// top entry, returns it and counts down. Inserting into a full table answers
// "full" before any search; entries above the count are never read, so the
// RAM needs no clearing.
module sorted_unique_set_table import sut_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_action,
    input  logic signed [VALUE_W-1:0] i_operand_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [2:0]                o_status,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic [COUNT_W-1:0]        o_entry_count
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sut_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sut_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_action        (i_action),
        .i_operand_value (i_operand_value),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_result_value  (o_result_value),
        .o_entry_count   (o_entry_count)
    );

`ifndef SYNTH
    // Result count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= COUNT_W'(DEPTH)))
        else $error("entry count above table depth");

    // A full refusal only comes from a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (o_entry_count == COUNT_W'(DEPTH)))
        else $error("full status with table not full");

    // Result register is loaded only when it is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_stat.out_free)
        else $error("result beat overwritten");

    // Search reads stay inside the open window
    a_probe_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.probe |-> w_stat.search_open)
        else $error("probe issued with empty search window");
`endif

endmodule

/* hdl/sut_ram.sv */
module sut_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read that holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/sut_datapath.sv */
module sut_datapath import sut_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [1:0]                i_action,
    input  logic signed [VALUE_W-1:0] i_operand_value,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic [2:0]                o_status,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic [COUNT_W-1:0]        o_entry_count
);

    // Control state
    logic [COUNT_W-1:0]        r_count;
    logic                      r_wv;
    logic                      r_out_valid;

    // Operation payload
    t_action                   r_action;
    logic signed [VALUE_W-1:0] r_value;
    logic [COUNT_W-1:0]        r_lo;
    logic [COUNT_W-1:0]        r_hi;
    logic                      r_found;
    logic [COUNT_W-1:0]        r_ptr;
    logic [ADDR_W-1:0]         r_wa;
    t_status                   r_out_status;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [COUNT_W-1:0]        r_out_count;

    // RAM ports
    logic                      w_re;
    logic [ADDR_W-1:0]         w_raddr;
    logic                      w_we;
    logic [ADDR_W-1:0]         w_waddr;
    logic [VALUE_W-1:0]        w_wdata;
    logic [VALUE_W-1:0]        w_rdata;

    // Search midpoint and helpers
    logic [COUNT_W:0]          w_sum;
    logic [COUNT_W-1:0]        w_mid;
    logic [COUNT_W-1:0]        w_ptr_dec;
    logic [COUNT_W-1:0]        w_count_dec;
    logic signed [VALUE_W-1:0] w_sel_value;

    assign w_sum       = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid       = w_sum[COUNT_W:1];
    assign w_ptr_dec   = r_ptr - COUNT_W'(1);
    assign w_count_dec = r_count - COUNT_W'(1);

    // Read address: search probe, shift source or top entry
    always_comb begin
        w_re    = i_cmd.probe | i_cmd.shift_rd | i_cmd.pop_rd;
        w_raddr = w_mid[ADDR_W-1:0];
        if (i_cmd.shift_rd) begin
            w_raddr = w_ptr_dec[ADDR_W-1:0];
        end else if (i_cmd.pop_rd) begin
            w_raddr = w_count_dec[ADDR_W-1:0];
        end
    end

    // Write address: operand at insert slot, else a moved entry one place up
    always_comb begin
        w_we    = i_cmd.place | r_wv;
        w_waddr = r_wa;
        w_wdata = w_rdata;
        if (i_cmd.place) begin
            w_waddr = r_lo[ADDR_W-1:0];
            w_wdata = r_value;
        end
    end

    sut_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Result value select
    always_comb begin
        unique case (i_cmd.vsel)
            VSEL_OPERAND: w_sel_value = r_value;
            VSEL_RDATA:   w_sel_value = w_rdata;
            default:      w_sel_value = '0;
        endcase
    end

    // Count, pending shift write, result beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wv <= i_cmd.shift_rd;
            if (i_cmd.place) begin
                r_count <= r_count + COUNT_W'(1);
            end else if (i_cmd.pop) begin
                r_count <= w_count_dec;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operation payload and search window
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_value  <= i_operand_value;
            r_lo     <= '0;
            r_hi     <= r_count;
            r_found  <= 1'b0;
            r_ptr    <= r_count;
        end
        if (i_cmd.eval) begin
            if ($signed(w_rdata) < r_value) begin
                r_lo <= w_mid + COUNT_W'(1);
            end else begin
                r_hi <= w_mid;
            end
            if (w_rdata == r_value) begin
                r_found <= 1'b1;
            end
        end
        if (i_cmd.shift_rd) begin
            r_ptr <= w_ptr_dec;
            r_wa  <= r_ptr[ADDR_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.status;
            r_out_value  <= w_sel_value;
            r_out_count  <= r_count;
        end
    end

    // Status to controller
    always_comb begin
        o_stat.action      = r_action;
        o_stat.full        = (r_count >= COUNT_W'(DEPTH));
        o_stat.empty       = (r_count == '0);
        o_stat.search_open = (r_lo < r_hi);
        o_stat.found       = r_found;
        o_stat.shift_more  = (r_ptr > r_lo);
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_value = r_out_value;
    assign o_entry_count  = r_out_count;

endmodule

/* hdl/sut_controller.sv */
module sut_controller import sut_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_PROBE,
        S_EVAL,
        S_SHIFT,
        S_PLACE,
        S_POP,
        S_FIN
    } t_state;

    t_state  r_state,      n_state;
    t_status r_fin_status, n_fin_status;
    t_vsel   r_fin_vsel,   n_fin_vsel;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_fin_status = r_fin_status;
        n_fin_vsel   = r_fin_vsel;
        o_cmd        = '0;
        o_cmd.status = r_fin_status;
        o_cmd.vsel   = r_fin_vsel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_state      = S_FIN;
                n_fin_status = ST_OK;
                n_fin_vsel   = VSEL_ZERO;
                unique case (i_stat.action)
                    ACT_INSERT: begin
                        if (i_stat.full) begin
                            n_fin_status = ST_FULL;
                        end else begin
                            n_state = S_PROBE;
                        end
                    end
                    ACT_REMOVE: begin
                        if (i_stat.empty) begin
                            n_fin_status = ST_EMPTY;
                        end else begin
                            o_cmd.pop_rd = 1'b1;
                            n_state      = S_POP;
                        end
                    end
                    ACT_LOOKUP: n_state = S_PROBE;
                    default:    n_state = S_FIN;
                endcase
            end
            // Binary search for the lower bound of the operand
            S_PROBE: begin
                if (i_stat.search_open) begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_EVAL;
                end else if (i_stat.action == ACT_INSERT) begin
                    if (i_stat.found) begin
                        n_state      = S_FIN;
                        n_fin_status = ST_DUP;
                        n_fin_vsel   = VSEL_ZERO;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_state      = S_FIN;
                    n_fin_status = i_stat.found ? ST_OK : ST_NOTFOUND;
                    n_fin_vsel   = i_stat.found ? VSEL_OPERAND : VSEL_ZERO;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_PROBE;
            end
            // Move larger entries up, one per cycle, top first
            S_SHIFT: begin
                if (i_stat.shift_more) begin
                    o_cmd.shift_rd = 1'b1;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place  = 1'b1;
                n_state      = S_FIN;
                n_fin_status = ST_OK;
                n_fin_vsel   = VSEL_ZERO;
            end
            S_POP: begin
                o_cmd.pop    = 1'b1;
                n_state      = S_FIN;
                n_fin_status = ST_OK;
                n_fin_vsel   = VSEL_RDATA;
            end
            // Hand the result to the output register once it is free
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fin_status <= ST_OK;
            r_fin_vsel   <= VSEL_ZERO;
        end else begin
            r_state      <= n_state;
            r_fin_status <= n_fin_status;
            r_fin_vsel   <= n_fin_vsel;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
